// ----- rtl/alc_pkg.sv -----
// Shared constants, types and byte functions for the acknowledgment line checker.
`default_nettype none

package alc_pkg;

	localparam int unsigned MAX_LINE = 255;
	localparam int POS_W = 8;
	localparam int CRC_W = 16;
	localparam int CNT_W = 32;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_LINE);
	localparam logic [POS_W-1:0] TRAILER_LEN = POS_W'(4);
	localparam logic [POS_W-1:0] PREFIX_LEN = POS_W'(4);

	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

	localparam logic [7:0] STAR_CHAR = 8'h2A;
	localparam logic [7:0] SPACE_CHAR = 8'h20;

	typedef enum logic [2:0] {
		RSN_OK       = 3'd0,
		RSN_NO_STAR  = 3'd1,
		RSN_CRC      = 3'd2,
		RSN_PREFIX   = 3'd3,
		RSN_NO_SPACE = 3'd4,
		RSN_COUNT    = 3'd5,
		RSN_TOO_LONG = 3'd6
	} reason_t;

	// Line state at the moment the last byte has been taken in.
	typedef struct packed {
		logic [CRC_W-1:0] head_crc;
		logic             star_vld;
		logic [POS_W-1:0] star_pos;
		logic [POS_W-1:0] last_ns_pos;
		logic [CRC_W-1:0] hex_val;
		logic             prefix_ok;
		logic             space_vld;
		logic [POS_W-1:0] space_pos;
		logic [CNT_W-1:0] count_val;
		logic             too_long;
	} line_snap_t;

	function automatic logic is_blank(input logic [7:0] b);
		return (b == SPACE_CHAR) || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
		input logic [7:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	// Upper bit flags a hex digit, lower four bits hold its value.
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [7:0] v;
		v = 8'h00;
		if (b >= 8'h30 && b <= 8'h39) begin
			v = b - 8'h30;
			return {1'b1, v[3:0]};
		end
		if (b >= 8'h41 && b <= 8'h46) begin
			v = b - 8'h37;
			return {1'b1, v[3:0]};
		end
		if (b >= 8'h61 && b <= 8'h66) begin
			v = b - 8'h57;
			return {1'b1, v[3:0]};
		end
		return 5'b0_0000;
	endfunction

	function automatic logic [7:0] prefix_char(input logic [1:0] p);
		logic [7:0] c;
		unique case (p)
			2'd0: c = 8'h41;
			2'd1: c = 8'h43;
			2'd2: c = 8'h4B;
			default: c = SPACE_CHAR;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/alc_line_track.sv -----
// Input register and per-byte line state: trimming, CRC, star trailer, prefix and count.
`default_nettype none

module alc_line_track import alc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] line_byte,
	input  wire logic       last_byte,
	input  wire logic       s2_ready,
	output logic            snap_load,
	output line_snap_t      snap
);

	logic             vld_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             fire;
	logic             in_take;

	logic [CRC_W-1:0] run_crc_q, run_crc_d;
	logic [CRC_W-1:0] head_crc_q, head_crc_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic             started_q, started_d;
	logic             star_vld_q, star_vld_d;
	logic [POS_W-1:0] star_pos_q, star_pos_d;
	logic [POS_W-1:0] last_ns_q, last_ns_d;
	logic [CRC_W-1:0] hex_q, hex_d;
	logic             hex_stop_q, hex_stop_d;
	logic             prefix_ok_q, prefix_ok_d;
	logic             space_vld_q, space_vld_d;
	logic [POS_W-1:0] space_pos_q, space_pos_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             count_end_q, count_end_d;
	logic             too_long_q, too_long_d;

	logic             blank;
	logic [4:0]       hex_dig;

	assign fire      = vld_s1 && (!last_s1 || s2_ready);
	assign in_stall  = vld_s1 && !fire;
	assign in_take   = in_valid && !in_stall;
	assign snap_load = fire && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_take) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= line_byte;
			last_s1 <= last_byte;
		end
	end

	assign blank   = is_blank(byte_s1);
	assign hex_dig = hex_digit(byte_s1);

	always_comb begin
		run_crc_d   = run_crc_q;
		head_crc_d  = head_crc_q;
		pos_d       = pos_q;
		started_d   = started_q;
		star_vld_d  = star_vld_q;
		star_pos_d  = star_pos_q;
		last_ns_d   = last_ns_q;
		hex_d       = hex_q;
		hex_stop_d  = hex_stop_q;
		prefix_ok_d = prefix_ok_q;
		space_vld_d = space_vld_q;
		space_pos_d = space_pos_q;
		count_d     = count_q;
		count_end_d = count_end_q;
		too_long_d  = too_long_q;
		if (started_q || !blank) begin
			started_d = 1'b1;
			if (pos_q == LAST_POS) begin
				if (!blank) begin
					too_long_d = 1'b1;
				end
			end else begin
				if (byte_s1 == STAR_CHAR) begin
					head_crc_d = run_crc_q;
					star_vld_d = 1'b1;
					star_pos_d = pos_q;
					hex_d      = '0;
					hex_stop_d = 1'b0;
				end else if (star_vld_q && !hex_stop_q &&
					(pos_q - star_pos_q) <= TRAILER_LEN) begin
					if (!hex_dig[4]) begin
						hex_stop_d = 1'b1;
					end else begin
						hex_d = {hex_q[CRC_W-5:0], hex_dig[3:0]};
					end
				end
				run_crc_d = crc_byte(run_crc_q, byte_s1);
				if (!blank) begin
					last_ns_d = pos_q;
				end
				if (pos_q < PREFIX_LEN && byte_s1 != prefix_char(pos_q[1:0])) begin
					prefix_ok_d = 1'b0;
				end
				if (pos_q >= PREFIX_LEN && !space_vld_q) begin
					if (byte_s1 == SPACE_CHAR) begin
						space_vld_d = 1'b1;
						space_pos_d = pos_q;
						count_end_d = 1'b1;
					end else if (!count_end_q) begin
						if (byte_s1 >= 8'h30 && byte_s1 <= 8'h39) begin
							count_d = {count_q[CNT_W-4:0], 3'b000} +
								{count_q[CNT_W-2:0], 1'b0} +
								CNT_W'(byte_s1[3:0]);
						end else begin
							count_end_d = 1'b1;
						end
					end
				end
				pos_d = pos_q + POS_W'(1);
			end
		end
	end

	always_comb begin
		snap.head_crc    = head_crc_d;
		snap.star_vld    = star_vld_d;
		snap.star_pos    = star_pos_d;
		snap.last_ns_pos = last_ns_d;
		snap.hex_val     = hex_d;
		snap.prefix_ok   = prefix_ok_d;
		snap.space_vld   = space_vld_d;
		snap.space_pos   = space_pos_d;
		snap.count_val   = count_d;
		snap.too_long    = too_long_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_crc_q   <= CRC_INIT;
			head_crc_q  <= CRC_INIT;
			pos_q       <= '0;
			started_q   <= 1'b0;
			star_vld_q  <= 1'b0;
			star_pos_q  <= '0;
			last_ns_q   <= '0;
			hex_q       <= '0;
			hex_stop_q  <= 1'b0;
			prefix_ok_q <= 1'b1;
			space_vld_q <= 1'b0;
			space_pos_q <= '0;
			count_q     <= '0;
			count_end_q <= 1'b0;
			too_long_q  <= 1'b0;
		end else if (fire) begin
			if (last_s1) begin
				run_crc_q   <= CRC_INIT;
				head_crc_q  <= CRC_INIT;
				pos_q       <= '0;
				started_q   <= 1'b0;
				star_vld_q  <= 1'b0;
				star_pos_q  <= '0;
				last_ns_q   <= '0;
				hex_q       <= '0;
				hex_stop_q  <= 1'b0;
				prefix_ok_q <= 1'b1;
				space_vld_q <= 1'b0;
				space_pos_q <= '0;
				count_q     <= '0;
				count_end_q <= 1'b0;
				too_long_q  <= 1'b0;
			end else begin
				run_crc_q   <= run_crc_d;
				head_crc_q  <= head_crc_d;
				pos_q       <= pos_d;
				started_q   <= started_d;
				star_vld_q  <= star_vld_d;
				star_pos_q  <= star_pos_d;
				last_ns_q   <= last_ns_d;
				hex_q       <= hex_d;
				hex_stop_q  <= hex_stop_d;
				prefix_ok_q <= prefix_ok_d;
				space_vld_q <= space_vld_d;
				space_pos_q <= space_pos_d;
				count_q     <= count_d;
				count_end_q <= count_end_d;
				too_long_q  <= too_long_d;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/alc_judge.sv -----
// Line snapshot register, final checks against the expected counter, and result register.
`default_nettype none

module alc_judge import alc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CNT_W-1:0] cfg_wr_data,
	input  wire logic             snap_load,
	input  wire line_snap_t       snap,
	output logic                  s2_ready,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  accepted,
	output logic [2:0]            reject_reason,
	output logic [CNT_W-1:0]      ack_counter,
	output logic [CRC_W-1:0]      received_crc,
	output logic [CRC_W-1:0]      computed_crc,
	output logic [POS_W-1:0]      status_start,
	output logic [POS_W-1:0]      status_length
);

	logic [CNT_W-1:0] expected_q;
	logic             vld_s2;
	line_snap_t       snap_s2;
	logic             out_vld_q;
	logic             out_ready;
	logic             out_load;

	reason_t          rsn;
	logic [CNT_W-1:0] cnt;
	logic [CRC_W-1:0] rx_crc;
	logic [CRC_W-1:0] hd_crc;
	logic [POS_W-1:0] st_start;
	logic [POS_W-1:0] st_len;
	logic [POS_W-1:0] trail_gap;

	reason_t          rsn_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CRC_W-1:0] rx_crc_q;
	logic [CRC_W-1:0] hd_crc_q;
	logic [POS_W-1:0] st_start_q;
	logic [POS_W-1:0] st_len_q;

	assign out_ready = !out_vld_q || !out_stall;
	assign s2_ready  = !vld_s2 || out_ready;
	assign out_load  = vld_s2 && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= '0;
		end else if (cfg_wr_en) begin
			expected_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (snap_load) begin
				vld_s2 <= 1'b1;
			end else if (out_load) begin
				vld_s2 <= 1'b0;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap_load) begin
			snap_s2 <= snap;
		end
	end

	assign trail_gap = snap_s2.last_ns_pos - snap_s2.star_pos;

	// Checks are ordered so that the first failing one names the reason.
	always_comb begin
		rsn      = RSN_OK;
		cnt      = '0;
		rx_crc   = '0;
		hd_crc   = '0;
		st_start = '0;
		st_len   = '0;
		if (snap_s2.too_long) begin
			rsn = RSN_TOO_LONG;
		end else if (!snap_s2.star_vld || trail_gap < TRAILER_LEN) begin
			rsn = RSN_NO_STAR;
		end else begin
			rx_crc = snap_s2.hex_val;
			hd_crc = snap_s2.head_crc;
			if (snap_s2.hex_val != snap_s2.head_crc) begin
				rsn = RSN_CRC;
			end else if (!snap_s2.prefix_ok || snap_s2.star_pos < PREFIX_LEN) begin
				rsn = RSN_PREFIX;
			end else if (!snap_s2.space_vld || snap_s2.space_pos > snap_s2.star_pos) begin
				rsn = RSN_NO_SPACE;
			end else begin
				rsn      = (snap_s2.count_val == expected_q) ? RSN_OK : RSN_COUNT;
				cnt      = snap_s2.count_val;
				st_start = snap_s2.space_pos + POS_W'(1);
				st_len   = snap_s2.star_pos - snap_s2.space_pos - POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsn_q      <= rsn;
			cnt_q      <= cnt;
			rx_crc_q   <= rx_crc;
			hd_crc_q   <= hd_crc;
			st_start_q <= st_start;
			st_len_q   <= st_len;
		end
	end

	assign out_valid     = out_vld_q;
	assign accepted      = (rsn_q == RSN_OK);
	assign reject_reason = rsn_q;
	assign ack_counter   = cnt_q;
	assign received_crc  = rx_crc_q;
	assign computed_crc  = hd_crc_q;
	assign status_start  = st_start_q;
	assign status_length = st_len_q;

endmodule

`default_nettype wire

// ----- rtl/ack_line_checker_unit.sv -----
// Top level of the acknowledgment line checker: byte tracking followed by the line verdict.
//
//   Channel  Direction  Handshake             Payload
//   cfg      in         cfg_wr_en             cfg_wr_data (expected counter)
//   in       in         in_valid / in_stall   line_byte, last_byte
//   out      out        out_valid / out_stall accepted, reject_reason, ack_counter,
//                                             received_crc, computed_crc,
//                                             status_start, status_length
//
// One byte item is taken every cycle unless a last byte waits on the snapshot register; the
// unrolled eight-bit CRC step sets the byte path. A verdict passes the snapshot, then the result register.
// Reset returns the line state to its start values and clears the expected counter.
// A stalled result holds in the output register while one more line closes behind it.
`default_nettype none

module ack_line_checker_unit import alc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CNT_W-1:0] cfg_wr_data,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [7:0]       line_byte,
	input  wire logic             last_byte,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  accepted,
	output logic [2:0]            reject_reason,
	output logic [CNT_W-1:0]      ack_counter,
	output logic [CRC_W-1:0]      received_crc,
	output logic [CRC_W-1:0]      computed_crc,
	output logic [POS_W-1:0]      status_start,
	output logic [POS_W-1:0]      status_length
);

	logic       s2_ready;
	logic       snap_load;
	line_snap_t snap;

	alc_line_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.line_byte (line_byte),
		.last_byte (last_byte),
		.s2_ready  (s2_ready),
		.snap_load (snap_load),
		.snap      (snap)
	);

	alc_judge u_judge (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.snap_load     (snap_load),
		.snap          (snap),
		.s2_ready      (s2_ready),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.accepted      (accepted),
		.reject_reason (reject_reason),
		.ack_counter   (ack_counter),
		.received_crc  (received_crc),
		.computed_crc  (computed_crc),
		.status_start  (status_start),
		.status_length (status_length)
	);

endmodule

`default_nettype wire

// ----- rtl/alc_checker.sv -----
// Port-level assertions for the acknowledgment line checker and their binding.
`default_nettype none

module alc_checker import alc_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             cfg_wr_en,
	input wire logic [CNT_W-1:0] cfg_wr_data,
	input wire logic             in_valid,
	input wire logic             in_stall,
	input wire logic [7:0]       line_byte,
	input wire logic             last_byte,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire logic             accepted,
	input wire logic [2:0]       reject_reason,
	input wire logic [CNT_W-1:0] ack_counter,
	input wire logic [CRC_W-1:0] received_crc,
	input wire logic [CRC_W-1:0] computed_crc,
	input wire logic [POS_W-1:0] status_start,
	input wire logic [POS_W-1:0] status_length
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(reject_reason) &&
		$stable(ack_counter) && $stable(computed_crc) && $stable(status_length))
		else $error("Stalled result changed.");

	a_accept_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (accepted == (reject_reason == RSN_OK)))
		else $error("Accept flag disagrees with the reason code.");

	a_crc_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (reject_reason == RSN_TOO_LONG || reject_reason == RSN_NO_STAR)
		|-> received_crc == '0 && computed_crc == '0)
		else $error("CRC fields set on a line without a trailer.");

	a_ok_crc_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (reject_reason == RSN_OK || reject_reason == RSN_COUNT ||
		reject_reason == RSN_PREFIX || reject_reason == RSN_NO_SPACE)
		|-> received_crc == computed_crc)
		else $error("Line passed the CRC check with differing CRCs.");

	a_status_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reject_reason != RSN_OK && reject_reason != RSN_COUNT
		|-> ack_counter == '0 && status_start == '0 && status_length == '0)
		else $error("Count or status fields set on a malformed line.");

endmodule

bind ack_line_checker_unit alc_checker u_alc_checker (.*);

`default_nettype wire

// ----- sim/tb_ack_line_checker_unit.sv -----
// Self-checking testbench for the acknowledgment line checker against predicted verdicts.
module tb_ack_line_checker_unit;
	import alc_pkg::*;

	localparam int HOLD_CYCLES = 120;
	localparam int SETTLE_CYCLES = 6;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [31:0] ACK_WORD = "ACK ";

	typedef logic [7:0] bytes_t[$];

	typedef struct packed {
		logic             ok;
		reason_t          why;
		logic [CNT_W-1:0] count;
		logic [CRC_W-1:0] crc_rx;
		logic [CRC_W-1:0] crc_calc;
		logic [POS_W-1:0] st_start;
		logic [POS_W-1:0] st_len;
	} verdict_t;

	bit clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CNT_W-1:0] cfg_wr_data;
	logic in_valid;
	logic in_stall;
	logic [7:0] line_byte;
	logic last_byte;
	logic out_valid;
	logic out_stall;
	logic accepted;
	logic [2:0] reject_reason;
	logic [CNT_W-1:0] ack_counter;
	logic [CRC_W-1:0] received_crc;
	logic [CRC_W-1:0] computed_crc;
	logic [POS_W-1:0] status_start;
	logic [POS_W-1:0] status_length;

	ack_line_checker_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.line_byte(line_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.accepted(accepted),
		.reject_reason(reject_reason),
		.ack_counter(ack_counter),
		.received_crc(received_crc),
		.computed_crc(computed_crc),
		.status_start(status_start),
		.status_length(status_length)
	);

	always #2 clk = ~clk;

	// Predicted line state and expected counter.
	logic [CNT_W-1:0] exp_counter;
	logic [CRC_W-1:0] ln_crc;
	logic [CRC_W-1:0] ln_head_crc;
	int ln_pos;
	logic ln_begun;
	int ln_star;
	int ln_last_ns;
	logic [CRC_W-1:0] ln_hex;
	logic ln_hex_done;
	logic ln_prefix_good;
	int ln_space;
	logic [CNT_W-1:0] ln_count;
	logic ln_count_done;
	logic ln_overlong;

	verdict_t verdicts_due[$];
	int errors;
	int bytes_sent;
	int verdicts_seen;
	int accepts_seen;
	int reason_seen[7];
	int send_idle_pct;
	int recv_idle_pct;
	int hold_req;
	int hold_seen;
	int hold_left;
	int quiet;

	function automatic logic blank_char(input logic [7:0] c);
		return c == SPACE_CHAR || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return c - "0";
		if (c >= "A" && c <= "F")
			return c - "A" + 10;
		if (c >= "a" && c <= "f")
			return c - "a" + 10;
		return -1;
	endfunction

	function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
		input logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = crc[CRC_W-1] ^ b[i];
			crc = {crc[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return crc;
	endfunction

	function automatic void clear_line_state();
		ln_crc = CRC_INIT;
		ln_head_crc = CRC_INIT;
		ln_pos = 0;
		ln_begun = 1'b0;
		ln_star = -1;
		ln_last_ns = 0;
		ln_hex = '0;
		ln_hex_done = 1'b0;
		ln_prefix_good = 1'b1;
		ln_space = -1;
		ln_count = '0;
		ln_count_done = 1'b0;
		ln_overlong = 1'b0;
	endfunction

	// Advances the predicted line by one byte and queues a verdict when the line closes.
	task automatic line_take(input logic [7:0] b, input logic fin);
		verdict_t v;
		int d;
		int p;
		logic blank;
		blank = blank_char(b);
		if (ln_begun || !blank) begin
			ln_begun = 1'b1;
			if (ln_pos >= MAX_LINE) begin
				if (!blank)
					ln_overlong = 1'b1;
			end else begin
				p = ln_pos;
				if (b == STAR_CHAR) begin
					ln_head_crc = ln_crc;
					ln_star = p;
					ln_hex = '0;
					ln_hex_done = 1'b0;
				end else if (ln_star >= 0 && !ln_hex_done && p - ln_star <= int'(TRAILER_LEN)) begin
					d = hex_nibble(b);
					if (d < 0)
						ln_hex_done = 1'b1;
					else
						ln_hex = {ln_hex[CRC_W-5:0], 4'(d)};
				end
				ln_crc = crc_step(ln_crc, b);
				if (!blank)
					ln_last_ns = p;
				if (p < int'(PREFIX_LEN) && b != ACK_WORD[31 - 8*p -: 8])
					ln_prefix_good = 1'b0;
				if (p >= int'(PREFIX_LEN) && ln_space < 0) begin
					if (b == SPACE_CHAR) begin
						ln_space = p;
						ln_count_done = 1'b1;
					end else if (!ln_count_done) begin
						if (b >= "0" && b <= "9")
							ln_count = ln_count * 10 + (b - 8'h30);
						else
							ln_count_done = 1'b1;
					end
				end
				ln_pos++;
			end
		end
		if (fin) begin
			v = '0;
			if (ln_overlong) begin
				v.why = RSN_TOO_LONG;
			end else if (ln_star < 0 || ln_last_ns - ln_star < int'(TRAILER_LEN)) begin
				v.why = RSN_NO_STAR;
			end else begin
				v.crc_rx = ln_hex;
				v.crc_calc = ln_head_crc;
				if (ln_hex != ln_head_crc) begin
					v.why = RSN_CRC;
				end else if (!ln_prefix_good || ln_star < int'(PREFIX_LEN)) begin
					v.why = RSN_PREFIX;
				end else if (ln_space < 0 || ln_space > ln_star) begin
					v.why = RSN_NO_SPACE;
				end else begin
					v.why = (ln_count == exp_counter) ? RSN_OK : RSN_COUNT;
					v.count = ln_count;
					v.st_start = POS_W'(ln_space + 1);
					v.st_len = POS_W'(ln_star - ln_space - 1);
				end
			end
			v.ok = (v.why == RSN_OK);
			verdicts_due.push_back(v);
			clear_line_state();
		end
	endtask

	task automatic compare_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (verdicts_due.size() == 0) begin
				errors++;
				$display("%0t: result with no line pending, expected none actual reason %0d",
					$time, reject_reason);
			end else begin
				want = verdicts_due.pop_front();
				compare_field("accepted", want.ok, accepted);
				compare_field("reject_reason", want.why, reject_reason);
				compare_field("ack_counter", want.count, ack_counter);
				compare_field("received_crc", want.crc_rx, received_crc);
				compare_field("computed_crc", want.crc_calc, computed_crc);
				compare_field("status_start", want.st_start, status_start);
				compare_field("status_length", want.st_len, status_length);
				verdicts_seen++;
				reason_seen[want.why]++;
				if (want.ok)
					accepts_seen++;
			end
		end
	end

	// Result stall: random, or a long hold when the test asks for one.
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet = 0;
		else
			quiet++;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		line_byte <= b;
		last_byte <= fin;
		do
			@(posedge clk);
		while (in_stall);
		line_take(b, fin);
		bytes_sent++;
	endtask

	task automatic send_line(input bytes_t f);
		for (int i = 0; i < f.size(); i++)
			send_byte(f[i], i == f.size() - 1);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_expected(input logic [CNT_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		exp_counter = v;
	endtask

	function automatic bytes_t text(input string s);
		bytes_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		return q;
	endfunction

	function automatic bytes_t seal(input bytes_t h, input logic lower);
		logic [CRC_W-1:0] c;
		string hx;
		c = CRC_INIT;
		foreach (h[i])
			c = crc_step(c, h[i]);
		hx = $sformatf("%h", c);
		if (!lower)
			hx = hx.toupper();
		h.push_back(STAR_CHAR);
		for (int i = 0; i < 4; i++)
			h.push_back(hx[i]);
		return h;
	endfunction

	function automatic logic [7:0] blank_pick();
		int k;
		k = $urandom_range(5);
		return (k == 5) ? SPACE_CHAR : 8'(8'h09 + k);
	endfunction

	function automatic bytes_t pad(input bytes_t f, input int lead, input int trail);
		repeat (lead) f.push_front(blank_pick());
		repeat (trail) f.push_back(blank_pick());
		return f;
	endfunction

	function automatic bytes_t ack_head(input logic [CNT_W-1:0] n, input int stat_n);
		bytes_t h;
		h = text($sformatf("ACK %0d ", n));
		repeat (stat_n) h.push_back(8'($urandom_range(8'h20, 8'h7E)));
		return h;
	endfunction

	// Mostly well-formed lines with random content, the rest broken lines and noise.
	task automatic send_random_line();
		bytes_t f;
		bytes_t h;
		int kind;
		int k;
		logic [CNT_W-1:0] n;
		logic lower;
		kind = $urandom_range(99);
		lower = $urandom_range(1);
		k = $urandom_range(3);
		n = (k == 0) ? CNT_W'($urandom) : (k == 1) ? exp_counter + 1 : exp_counter;
		if (kind < 15) begin
			repeat ($urandom_range(1, 16)) f.push_back(8'($urandom_range(255)));
		end else begin
			h = ack_head(n, $urandom_range(6));
			if (kind >= 85) begin
				k = $urandom_range(4);
				if (k == 0)
					h = text($sformatf("ACK %0d", n));
				else if (k == 1)
					h[$urandom_range(3)] = 8'($urandom_range(255));
			end
			f = seal(h, lower);
			if (kind >= 70 && kind < 85) begin
				k = $urandom_range(f.size() - 1);
				f[k] = f[k] ^ 8'(1 << $urandom_range(7));
			end else if (kind >= 85 && k == 2) begin
				repeat ($urandom_range(1, 4)) void'(f.pop_back());
			end else if (kind >= 85 && k == 3) begin
				f[f.size() - 1 - $urandom_range(3)] = 8'($urandom_range(8'h67, 8'h7E));
			end else if (kind >= 85 && k == 4) begin
				repeat ($urandom_range(1, 3)) f.push_back(8'($urandom_range(8'h21, 8'h7E)));
			end
			f = pad(f, $urandom_range(2), $urandom_range(2));
		end
		send_line(f);
	endtask

	task automatic test_directed_cases();
		bytes_t f;
		send_line(pad(seal(text("ACK 0 ok"), 1'b0), 1, 1));
		send_line(text(" \t\r"));
		send_line(text("ACK 0 ok"));
		send_line(text("ACK 0 a*12"));
		send_line(text("ACK 0 ok*0000"));
		send_line(seal(text("ACX 0 ok"), 1'b1));
		send_line(seal(text("AC"), 1'b0));
		send_line(seal(text("ACK 7"), 1'b0));
		send_line(seal(text("ACK 12x 9"), 1'b1));
		send_line(text("ACK 0 *1g23"));
		f = {8'h00, 8'h7F, 8'h80, 8'hFF};
		send_line(f);
	endtask

	task automatic test_counter_extremes();
		write_expected(32'hFFFF_FFFF);
		send_line(seal(text("ACK 4294967295 max"), 1'b0));
		send_line(seal(text("ACK 4294967296 wrap"), 1'b1));
		write_expected(32'h0000_0000);
		send_line(seal(text("ACK 0 "), 1'b0));
	endtask

	// A line of exactly the maximum trimmed length passes; one more visible byte is too long.
	task automatic test_line_limit();
		bytes_t h;
		bytes_t f;
		h = text("ACK 0 ");
		repeat (MAX_LINE - 11) h.push_back(8'($urandom_range(8'h21, 8'h7E)));
		f = seal(h, 1'b0);
		send_line(pad(f, 2, 3));
		f.push_back("Z");
		send_line(pad(f, 0, 2));
	endtask

	task automatic test_random_traffic(input logic [CNT_W-1:0] counter, input int n_bytes);
		int goal;
		write_expected(counter);
		goal = bytes_sent + n_bytes;
		while (bytes_sent < goal)
			send_random_line();
	endtask

	task automatic test_backpressure();
		hold_req++;
		repeat (8) send_random_line();
		wait_idle();
		repeat (2) send_random_line();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		line_byte = '0;
		last_byte = 1'b0;
		out_stall = 1'b0;
		exp_counter = '0;
		clear_line_state();
		send_idle_pct = 27;
		recv_idle_pct = 68;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_counter_extremes();
		test_line_limit();
		test_random_traffic(CNT_W'($urandom), 80);
		send_idle_pct = 68;
		recv_idle_pct = 27;
		test_random_traffic(CNT_W'($urandom), 80);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(32'h0000_0000, 80);
		test_backpressure();

		wait_idle();
		$display("Sent %0d bytes; checked %0d line verdicts, %0d of them accepted.",
			bytes_sent, verdicts_seen, accepts_seen);
		$display({"Rejects by reason: no star %0d, crc %0d, prefix %0d, ",
			"no space %0d, count %0d, long %0d."},
			reason_seen[RSN_NO_STAR], reason_seen[RSN_CRC], reason_seen[RSN_PREFIX],
			reason_seen[RSN_NO_SPACE], reason_seen[RSN_COUNT], reason_seen[RSN_TOO_LONG]);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
